[rtl/core/text_line_annotator_unit_defines.svh]
// ============================================================================
// text_line_annotator_unit defines
// Assertion macros used by the annotator byte sequencer; ASSERT_OFF removes them.
// ============================================================================
`ifndef TEXT_LINE_ANNOTATOR_UNIT_DEFINES_SVH
`define TEXT_LINE_ANNOTATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLA_ASSERT_NEVER(lbl, cond, msg) `TLA_ASSERT(lbl, !(cond), msg)
`else
`define TLA_ASSERT(lbl, prop, msg)
`define TLA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/core/tla_pkg.sv]
// ============================================================================
// tla_pkg
// Types, register map and character constants of the text line annotator.
// ============================================================================
package tla_pkg;

    localparam int NUMBER_DIGITS_DEF = 8;
    localparam int CMDQ_DEPTH        = 2;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef enum logic [2:0] {
        REG_NUMBER_MODE      = 3'd0,
        REG_SHOW_ENDS        = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_TABS        = 3'd3,
        REG_SHOW_NONPRINTING = 3'd4
    } reg_idx_t;

    localparam logic [1:0] NM_ALL      = 2'd1;
    localparam logic [1:0] NM_NONBLANK = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_DASH  = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_QMARK = 8'd63;
    localparam logic [7:0] CH_I     = 8'd73;
    localparam logic [7:0] CH_M     = 8'd77;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_HIGH_LO = 8'd128;
    localparam logic [7:0] CH_HIGH_HI = 8'd160;
    localparam logic [7:0] CH_CTRL_END = 8'd32;
    localparam logic [7:0] CARET_OFS = 8'd64;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } out_item_t;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       show_ends;
        logic       squeeze_blank;
        logic       show_tabs;
        logic       show_nonprinting;
    } cfg_t;

    // body rendering of one input byte
    typedef enum logic [1:0] {
        K_PLAIN  = 2'd0,
        K_PAIR   = 2'd1,
        K_META   = 2'd2,
        K_DOLLAR = 2'd3
    } kind_t;

    typedef struct packed {
        logic       num_en;
        kind_t      kind;
        logic [7:0] ch;
    } cmd_t;

endpackage

[rtl/core/text_line_annotator_unit.sv]
// ============================================================================
// text_line_annotator_unit
// Streaming text annotator: line numbers, blank line squeezing and escapes.
// ============================================================================
// An input byte that renders to one byte passes the byte sequencer at one
// per cycle while the result word is empty or popped; a byte that expands
// holds the queue head until all its bytes are out: two for a caret or
// dollar escape, four for an M- escape, plus max(6, NUMBER_DIGITS digits
// used) + 1 when a line number is printed. A dropped blank line never
// reaches the sequencer. A two-entry command queue decouples input from
// output, so input stalls (full) only while the sequencer is still
// expanding or its result word is not taken. No clearing pass after reset.
module text_line_annotator_unit #(
    parameter int NUMBER_DIGITS = tla_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  tla_pkg::in_item_t          item,
    output logic                       empty,
    input  logic                       pop,
    output tla_pkg::out_item_t         result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tla_pkg::CFG_AW-1:0] paddr,
    input  logic [tla_pkg::CFG_DW-1:0] pwdata,
    output logic [tla_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import tla_pkg::*;

    localparam int NUM_W = NUMBER_DIGITS * 4;

    cfg_t             cfg;
    logic             q_push;
    cmd_t             q_cmd;
    logic [NUM_W-1:0] q_num;
    logic             q_pop;
    logic             head_valid;
    cmd_t             head_cmd;
    logic [NUM_W-1:0] head_num;

    tla_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tla_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .push   (push),
        .item   (item),
        .q_full (full),
        .q_push (q_push),
        .q_cmd  (q_cmd),
        .q_num  (q_num)
    );

    tla_cmdq #(
        .NUM_W (NUM_W)
    ) u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (q_push),
        .wr_cmd     (q_cmd),
        .wr_num     (q_num),
        .full       (full),
        .rd         (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_num   (head_num)
    );

    tla_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_num   (head_num),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

[rtl/core/tla_cfg.sv]
// ============================================================================
// tla_cfg
// APB register file holding the annotator options.
// ============================================================================
module tla_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tla_pkg::CFG_AW-1:0] paddr,
    input  logic [tla_pkg::CFG_DW-1:0] pwdata,
    output logic [tla_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output tla_pkg::cfg_t              cfg
);
    import tla_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_idx_t   idx;
    logic       wr;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_NUMBER_MODE:      cfg_next.number_mode      = pwdata[1:0];
                REG_SHOW_ENDS:        cfg_next.show_ends        = pwdata[0];
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = pwdata[0];
                REG_SHOW_TABS:        cfg_next.show_tabs        = pwdata[0];
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_NUMBER_MODE:      prdata = {{(CFG_DW-2){1'b0}}, cfg_reg.number_mode};
            REG_SHOW_ENDS:        prdata = {{(CFG_DW-1){1'b0}}, cfg_reg.show_ends};
            REG_SQUEEZE_BLANK:    prdata = {{(CFG_DW-1){1'b0}}, cfg_reg.squeeze_blank};
            REG_SHOW_TABS:        prdata = {{(CFG_DW-1){1'b0}}, cfg_reg.show_tabs};
            REG_SHOW_NONPRINTING: prdata = {{(CFG_DW-1){1'b0}}, cfg_reg.show_nonprinting};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/tla_front.sv]
// ============================================================================
// tla_front
// Accepts input bytes, tracks segments and the BCD line counter, and
// classifies each byte into a rendering command.
// ============================================================================
module tla_front #(
    parameter int NUMBER_DIGITS = tla_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tla_pkg::cfg_t              cfg,
    input  logic                       push,
    input  tla_pkg::in_item_t          item,
    input  logic                       q_full,
    output logic                       q_push,
    output tla_pkg::cmd_t              q_cmd,
    output logic [NUMBER_DIGITS*4-1:0] q_num
);
    import tla_pkg::*;

    localparam int NUM_W = NUMBER_DIGITS * 4;

    logic             at_line_start_reg;
    logic             at_line_start_next;
    logic             prev_blank_reg;
    logic             prev_blank_next;
    logic [NUM_W-1:0] line_number_reg;
    logic [NUM_W-1:0] line_number_next;

    logic [NUM_W-1:0] bumped;
    logic             accept;
    logic             seg;
    logic             blank;
    logic             drop;
    logic             num_en;
    logic [7:0]       b;
    cmd_t             cmd;

    assign b      = item.in_byte;
    assign accept = push && !q_full;
    assign seg    = item.first_of_file || at_line_start_reg;
    assign blank  = (b == CH_LF);
    assign drop   = seg && cfg.squeeze_blank && prev_blank_reg && blank;
    assign num_en = at_line_start_reg &&
                    ((cfg.number_mode == NM_ALL) ||
                     ((cfg.number_mode == NM_NONBLANK) && !blank));

    // saturating BCD increment
    always_comb
    begin
        logic [3:0] d;
        logic       carry;
        logic       all_nine;
        carry    = 1'b1;
        all_nine = 1'b1;
        bumped   = line_number_reg;
        for (int k = 0; k < NUMBER_DIGITS; k++)
        begin
            d = line_number_reg[4*k +: 4];
            if (d != 4'd9)
            begin
                all_nine = 1'b0;
            end
            if (carry)
            begin
                bumped[4*k +: 4] = (d >= 4'd9) ? 4'd0 : d + 4'd1;
                carry            = (d >= 4'd9);
            end
        end
        if (all_nine)
        begin
            bumped = line_number_reg;
        end
    end

    always_comb
    begin
        cmd.num_en = num_en;
        cmd.kind   = K_PLAIN;
        cmd.ch     = b;
        priority if (b == CH_TAB && cfg.show_tabs)
        begin
            cmd.kind = K_PAIR;
            cmd.ch   = CH_I;
        end
        else if (b == CH_LF)
        begin
            cmd.kind = cfg.show_ends ? K_DOLLAR : K_PLAIN;
            cmd.ch   = CH_LF;
        end
        else if (cfg.show_nonprinting && b < CH_CTRL_END && b != CH_TAB)
        begin
            cmd.kind = K_PAIR;
            cmd.ch   = b + CARET_OFS;
        end
        else if (cfg.show_nonprinting && b == CH_DEL)
        begin
            cmd.kind = K_PAIR;
            cmd.ch   = CH_QMARK;
        end
        else if (cfg.show_nonprinting && b >= CH_HIGH_LO && b < CH_HIGH_HI)
        begin
            cmd.kind = K_META;
            cmd.ch   = b - CARET_OFS;
        end
        else
        begin
            cmd.kind = K_PLAIN;
            cmd.ch   = b;
        end
    end

    assign q_push = accept && !drop;
    assign q_cmd  = cmd;
    assign q_num  = bumped;

    always_comb
    begin
        at_line_start_next = at_line_start_reg;
        prev_blank_next    = prev_blank_reg;
        line_number_next   = line_number_reg;
        if (accept && !drop)
        begin
            at_line_start_next = blank;
            if (seg)
            begin
                prev_blank_next = blank;
            end
            if (num_en)
            begin
                line_number_next = bumped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            prev_blank_reg    <= 1'b0;
            line_number_reg   <= '0;
        end
        else
        begin
            at_line_start_reg <= at_line_start_next;
            prev_blank_reg    <= prev_blank_next;
            line_number_reg   <= line_number_next;
        end
    end

endmodule

[rtl/core/tla_cmdq.sv]
// ============================================================================
// tla_cmdq
// Short command queue between the classifier and the byte sequencer.
// ============================================================================
module tla_cmdq #(
    parameter int NUM_W = tla_pkg::NUMBER_DIGITS_DEF * 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  tla_pkg::cmd_t    wr_cmd,
    input  logic [NUM_W-1:0] wr_num,
    output logic             full,
    input  logic             rd,
    output logic             head_valid,
    output tla_pkg::cmd_t    head_cmd,
    output logic [NUM_W-1:0] head_num
);
    import tla_pkg::*;

    localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t             cmd_mem [CMDQ_DEPTH];
    logic [NUM_W-1:0] num_mem [CMDQ_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;

    assign full       = (cnt_reg == CW'(CMDQ_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_num   = num_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            cmd_mem[wr_ptr_reg] <= wr_cmd;
            num_mem[wr_ptr_reg] <= wr_num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[rtl/core/tla_back.sv]
// ============================================================================
// tla_back
// Byte sequencer: expands one command into line number, tab and body bytes,
// one byte per cycle into the result register while it is empty or popped.
// ============================================================================
`include "text_line_annotator_unit_defines.svh"

module tla_back #(
    parameter int NUMBER_DIGITS = tla_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  tla_pkg::cmd_t              head_cmd,
    input  logic [NUMBER_DIGITS*4-1:0] head_num,
    output logic                       q_pop,
    output logic                       empty,
    input  logic                       pop,
    output tla_pkg::out_item_t         result
);
    import tla_pkg::*;

    localparam int MAXW = (NUMBER_DIGITS > 6) ? NUMBER_DIGITS : 6;
    localparam int PW   = $clog2(MAXW + 1);
    localparam int DW   = $clog2(NUMBER_DIGITS);

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_NUM   = 4'b0010,
        PH_TAB   = 4'b0100,
        PH_BODY  = 4'b1000
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [1:0] bidx_reg;
    logic [1:0] bidx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_next;

    logic [3:0]    digs [NUMBER_DIGITS];
    logic [PW-1:0] top;
    logic [PW-1:0] width;
    phase_t        eff_phase;
    logic [PW-1:0] eff_pos;
    logic [1:0]    eff_bidx;
    logic [3:0]    dig;
    logic [7:0]    byte_out;
    logic          last;
    logic          advance;

    always_comb
    begin
        top = PW'(1);
        for (int k = 0; k < NUMBER_DIGITS; k++)
        begin
            digs[k] = head_num[4*k +: 4];
            if (head_num[4*k +: 4] != 4'd0)
            begin
                top = PW'(k + 1);
            end
        end
        width = (top > PW'(6)) ? top : PW'(6);
    end

    always_comb
    begin
        eff_phase = phase_reg;
        eff_pos   = pos_reg;
        eff_bidx  = bidx_reg;
        if (phase_reg == PH_START)
        begin
            eff_bidx = 2'd0;
            if (head_cmd.num_en)
            begin
                eff_phase = PH_NUM;
                eff_pos   = width - 1'b1;
            end
            else
            begin
                eff_phase = PH_BODY;
            end
        end
    end

    assign dig = digs[eff_pos[DW-1:0]];

    always_comb
    begin
        byte_out   = head_cmd.ch;
        last       = 1'b0;
        phase_next = eff_phase;
        pos_next   = eff_pos;
        bidx_next  = eff_bidx;
        unique case (eff_phase)
            PH_NUM:
            begin
                if (eff_pos >= top)
                begin
                    byte_out = CH_SPACE;
                end
                else
                begin
                    byte_out = CH_ZERO + {4'd0, (dig > 4'd9) ? 4'd9 : dig};
                end
                if (eff_pos == '0)
                begin
                    phase_next = PH_TAB;
                end
                else
                begin
                    pos_next = eff_pos - 1'b1;
                end
            end
            PH_TAB:
            begin
                byte_out   = CH_TAB;
                phase_next = PH_BODY;
                bidx_next  = 2'd0;
            end
            PH_BODY:
            begin
                bidx_next = eff_bidx + 1'b1;
                unique case (head_cmd.kind)
                    K_PLAIN:
                    begin
                        byte_out = head_cmd.ch;
                        last     = 1'b1;
                    end
                    K_PAIR:
                    begin
                        byte_out = (eff_bidx == 2'd0) ? CH_CARET : head_cmd.ch;
                        last     = (eff_bidx == 2'd1);
                    end
                    K_DOLLAR:
                    begin
                        byte_out = (eff_bidx == 2'd0) ? CH_DOLLAR : CH_LF;
                        last     = (eff_bidx == 2'd1);
                    end
                    K_META:
                    begin
                        unique case (eff_bidx)
                            2'd0:    byte_out = CH_M;
                            2'd1:    byte_out = CH_DASH;
                            2'd2:    byte_out = CH_CARET;
                            default: byte_out = head_cmd.ch;
                        endcase
                        last = (eff_bidx == 2'd3);
                    end
                    default:
                    begin
                        byte_out = head_cmd.ch;
                        last     = 1'b1;
                    end
                endcase
                if (last)
                begin
                    phase_next = PH_START;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    assign advance = head_valid && (!out_valid_reg || pop);
    assign q_pop   = advance && last;
    assign empty   = !out_valid_reg;
    assign result  = out_item_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            out_valid_next         = 1'b1;
            out_item_next.out_byte = byte_out;
            out_item_next.run_end  = last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            pos_reg       <= '0;
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                bidx_reg  <= bidx_next;
            end
        end
    end

    `TLA_ASSERT(a_num_needs_cmd, (phase_reg == PH_NUM) |-> (head_valid && head_cmd.num_en), "number phase without numbered command")
    `TLA_ASSERT_NEVER(a_idle_mid_cmd, !head_valid && (phase_reg != PH_START), "sequencer mid command with empty queue")
    `TLA_ASSERT_NEVER(a_meta_index, (phase_reg == PH_BODY) && (bidx_reg >= 2'd2) && (head_cmd.kind != K_META), "body index beyond short escape")

endmodule
